/* src/aes_cbc_pkg.sv */
// ----------------------------------------------------------------------------
// aes_cbc_pkg
// Shared types, constants and round functions of the AES-256 CBC cipher core.
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

    localparam int NumRounds   = 14;
    localparam int NumKeyWords = 60;
    localparam int KeyAddrW    = 6;
    localparam int RoundW      = 4;
    localparam int ApbAddrW    = 6;

    // register indexes of the configuration port
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_IVH   = 3'd4;
    localparam logic [2:0] REG_IVL   = 3'd5;
    localparam logic [2:0] REG_DEC   = 3'd6;
    localparam logic [2:0] REG_CHAIN = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_OUTPUT,
        ST_PADBLK
    } state_t;

    // request from the controller to the key schedule unit
    typedef struct packed {
        logic         start;
        logic [255:0] key;
    } ks_ctrl_t;

    typedef struct packed {
        logic busy;
    } ks_stat_t;

    function automatic logic [7:0] sbox_fwd(input logic [7:0] b);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[b];
    endfunction

    function automatic logic [7:0] sbox_inv(input logic [7:0] b);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[b];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]), sbox_fwd(w[7:0])};
    endfunction

    // byte i of the block sits in bits 127-8i .. 120-8i
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic do_mix);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, x0, x1, x2, x3;
        t = '0;
        // sub bytes and shift rows
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127 - 8*(r + 4*c) -: 8] = sbox_fwd(get_byte(s, r + 4*((c + r) & 3)));
        if (do_mix)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = get_byte(t, 4*c);   a1 = get_byte(t, 4*c+1);
                a2 = get_byte(t, 4*c+2); a3 = get_byte(t, 4*c+3);
                x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
                t[127 - 32*c -: 32] = {x0 ^ x1 ^ a1 ^ a2 ^ a3,
                                       a0 ^ x1 ^ x2 ^ a2 ^ a3,
                                       a0 ^ a1 ^ x2 ^ x3 ^ a3,
                                       x0 ^ a0 ^ a1 ^ a2 ^ x3};
            end
        end
        return t;
    endfunction

    // inverse shift rows and inverse sub bytes
    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127 - 8*(r + 4*((c + r) & 3)) -: 8] = sbox_inv(get_byte(s, r + 4*c));
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a [4];
        logic [7:0]   m2 [4];
        logic [7:0]   m4 [4];
        logic [7:0]   m8 [4];
        logic [7:0]   e [4];
        logic [7:0]   b [4];
        logic [7:0]   d [4];
        logic [7:0]   n [4];
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                a[j]  = get_byte(s, 4*c + j);
                m2[j] = xtime(a[j]);
                m4[j] = xtime(m2[j]);
                m8[j] = xtime(m4[j]);
                n[j]  = m8[j] ^ a[j];
                b[j]  = n[j] ^ m2[j];
                d[j]  = n[j] ^ m4[j];
                e[j]  = m8[j] ^ m4[j] ^ m2[j];
            end
            t[127 - 32*c -: 32] = {e[0] ^ b[1] ^ d[2] ^ n[3],
                                   n[0] ^ e[1] ^ b[2] ^ d[3],
                                   d[0] ^ n[1] ^ e[2] ^ b[3],
                                   b[0] ^ d[1] ^ n[2] ^ e[3]};
        end
        return t;
    endfunction

endpackage

/* src/aes_cbc_if.sv */
// ----------------------------------------------------------------------------
// aes_cbc_in_if / aes_cbc_out_if
// Valid/ready channels carrying input blocks and result blocks.
// ----------------------------------------------------------------------------
interface aes_cbc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  valid_bytes;
    logic        last_block;

    modport source (output valid, data_high, data_low, valid_bytes, last_block, input ready);
    modport sink (input valid, data_high, data_low, valid_bytes, last_block, output ready);
endinterface

interface aes_cbc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_data_high;
    logic [63:0] out_data_low;
    logic [4:0]  out_valid_bytes;
    logic        out_last;

    modport source (output valid, out_data_high, out_data_low, out_valid_bytes, out_last,
                    input ready);
    modport sink (input valid, out_data_high, out_data_low, out_valid_bytes, out_last,
                  output ready);
endinterface

/* src/aes_cbc_ram.sv */
// ----------------------------------------------------------------------------
// aes_cbc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module aes_cbc_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

/* src/aes_cbc_keysched.sv */
// ----------------------------------------------------------------------------
// aes_cbc_keysched
// Key expansion into the round key memory, one word a cycle, plus the read
// port the round datapath uses for four words of one round key at a time.
// ----------------------------------------------------------------------------
module aes_cbc_keysched (
    input  logic                         clk,
    input  logic                         rst_n,
    input  aes_cbc_pkg::ks_ctrl_t        ctrl,
    output aes_cbc_pkg::ks_stat_t        stat,
    input  logic [aes_cbc_pkg::RoundW-1:0] rd_round,
    output logic [127:0]                 rnd_key
);
    import aes_cbc_pkg::*;

    // a window of the last eight words stands in for reads of words i-1, i-8
    logic [31:0]         win_reg [8];
    logic [31:0]         win_next [8];
    logic [KeyAddrW-1:0] idx_reg, idx_next;
    logic [7:0]          rc_reg, rc_next;
    logic                busy_reg, busy_next;
    logic [31:0]         temp, new_word;
    logic                we;
    logic [KeyAddrW-1:0] waddr;
    logic [31:0]         wdata;
    logic [31:0]         bank_q [4];

    // next word of the schedule
    always_comb
    begin
        temp = win_reg[7];
        if (idx_reg[2:0] == 3'd0)
            temp = sub_word({win_reg[7][23:0], win_reg[7][31:24]}) ^ {rc_reg, 24'h0};
        else if (idx_reg[2:0] == 3'd4)
            temp = sub_word(win_reg[7]);
        new_word = win_reg[0] ^ temp;
    end

    always_comb
    begin
        win_next  = win_reg;
        idx_next  = idx_reg;
        rc_next   = rc_reg;
        busy_next = busy_reg;
        we        = 1'b0;
        waddr     = idx_reg;
        wdata     = new_word;
        if (ctrl.start)
        begin
            for (int i = 0; i < 8; i++)
                win_next[i] = ctrl.key[255 - 32*i -: 32];
            idx_next  = '0;
            rc_next   = 8'h01;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            we = 1'b1;
            if (idx_reg < KeyAddrW'(8))
                wdata = win_reg[idx_reg[2:0]];
            else
            begin
                for (int i = 0; i < 7; i++)
                    win_next[i] = win_reg[i+1];
                win_next[7] = new_word;
                if (idx_reg[2:0] == 3'd0)
                    rc_next = xtime(rc_reg);
            end
            idx_next = idx_reg + KeyAddrW'(1);
            if (idx_reg == KeyAddrW'(NumKeyWords - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            rc_reg   <= 8'h01;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            rc_reg   <= rc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    // four banks by word column, so one round key is one read
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        aes_cbc_ram #(.Width(32), .Depth(16)) u_ram (
            .clk     (clk),
            .wr_en   (we && (waddr[1:0] == 2'(b))),
            .wr_addr (waddr[5:2]),
            .wr_data (wdata),
            .rd_addr (rd_round),
            .rd_data (bank_q[b])
        );
    end

    assign rnd_key = {bank_q[0], bank_q[1], bank_q[2], bank_q[3]};
    assign stat.busy = busy_reg;
endmodule

/* src/aes_cbc_datapath.sv */
// ----------------------------------------------------------------------------
// aes_cbc_datapath
// Round state register and one shared encrypt or decrypt round a cycle while step is high.
// ----------------------------------------------------------------------------
module aes_cbc_datapath (
    input  logic                         clk,
    input  logic                         load,
    input  logic [127:0]                 load_value,
    input  logic                         step,
    input  logic                         decrypt,
    input  logic [aes_cbc_pkg::RoundW-1:0] round,
    input  logic [127:0]                 rnd_key,
    output logic [127:0]                 state_out
);
    import aes_cbc_pkg::*;

    logic [127:0] state_reg, state_next;
    logic [127:0] enc_val, dec_val;
    logic [127:0] step_val;
    logic         first;

    // the first step is the plain key addition in either direction
    always_comb
    begin
        first   = decrypt ? (round == RoundW'(NumRounds)) : (round == '0);
        enc_val = fwd_round(state_reg, round != RoundW'(NumRounds)) ^ rnd_key;
        dec_val = inv_sub_shift(state_reg) ^ rnd_key;
        if (round != '0)
            dec_val = inv_mix(dec_val);
        step_val = first ? (state_reg ^ rnd_key) : (decrypt ? dec_val : enc_val);
        state_next = state_reg;
        if (load)
            state_next = load_value;
        else if (step)
            state_next = step_val;
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    // state after the round of this cycle, so the last round is seen as it ends
    assign state_out = step_val;
endmodule

/* src/aes256_cbc_cipher_core.sv */
// ----------------------------------------------------------------------------
// aes256_cbc_cipher_core
// AES-256 block cipher with optional CBC chaining, PKCS7 padding and pad stripping.
// ----------------------------------------------------------------------------
// From request to result, a block is first loaded into the state, then waits
// for the registered read of the round key memory, then passes through the
// single shared round unit (initial key addition plus 14 rounds), each step
// fed by one read of the round key memory. The first block of a message first
// waits while the key schedule writes its 60 words into memory, one per cycle.
// A final full block when encrypting with chaining on adds a padding block.
// ----------------------------------------------------------------------------
module aes256_cbc_cipher_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aes_cbc_pkg::ApbAddrW-1:0] paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready,
    aes_cbc_in_if.sink                      in_ch,
    aes_cbc_out_if.source                   out_ch
);
    import aes_cbc_pkg::*;

    // configuration registers
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, ivh_reg, ivl_reg;
    logic        dec_reg, chain_en_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            ivh_reg      <= '0;
            ivl_reg      <= '0;
            dec_reg      <= 1'b0;
            chain_en_reg <= 1'b1;
        end
        else if (wr_en && paddr[2:0] == 3'd0)
        begin
            unique case (reg_idx)
                REG_KEY0:  key0_reg     <= pwdata;
                REG_KEY1:  key1_reg     <= pwdata;
                REG_KEY2:  key2_reg     <= pwdata;
                REG_KEY3:  key3_reg     <= pwdata;
                REG_IVH:   ivh_reg      <= pwdata;
                REG_IVL:   ivl_reg      <= pwdata;
                REG_DEC:   dec_reg      <= pwdata[0];
                REG_CHAIN: chain_en_reg <= pwdata[0];
                default:   ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2:0] == 3'd0)
        begin
            unique case (reg_idx)
                REG_KEY0:  prdata = key0_reg;
                REG_KEY1:  prdata = key1_reg;
                REG_KEY2:  prdata = key2_reg;
                REG_KEY3:  prdata = key3_reg;
                REG_IVH:   prdata = ivh_reg;
                REG_IVL:   prdata = ivl_reg;
                REG_DEC:   prdata = {63'd0, dec_reg};
                REG_CHAIN: prdata = {63'd0, chain_en_reg};
                default:   prdata = '0;
            endcase
        end
    end

    // control state
    state_t              st_reg, st_next;
    logic                in_msg_reg, in_msg_next;
    logic [127:0]        chain_reg, chain_next;
    logic [127:0]        blk_reg, blk_next;
    logic                last_reg, last_next;
    logic                dec_op_reg, dec_op_next;
    logic                ecb_reg, ecb_next;
    logic                extra_reg, extra_next;
    logic [RoundW-1:0]   rnd_reg, rnd_next;
    logic                step_reg, step_next;
    logic [127:0]        res_reg, res_next;
    logic [4:0]          ovb_reg, ovb_next;
    logic                olast_reg, olast_next;
    ks_ctrl_t            ks_ctrl;
    ks_stat_t            ks_stat;
    logic [127:0]        rnd_key;
    logic [127:0]        dp_state;
    logic                dp_load;
    logic [127:0]        dp_load_val;
    logic                in_acc, out_acc;
    logic [4:0]          vb_sat;
    logic [127:0]        padded, plain, res_val;
    logic [7:0]          pad_byte;
    logic                done;

    assign in_ch.ready = (st_reg == ST_IDLE);
    assign in_acc = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign done = dec_op_reg ? (rnd_reg == '0) : (rnd_reg == RoundW'(NumRounds));

    // input padding for the encrypt direction
    always_comb
    begin
        vb_sat = (in_ch.valid_bytes > 5'd16 || !in_ch.last_block) ? 5'd16 : in_ch.valid_bytes;
        padded = {in_ch.data_high, in_ch.data_low};
        for (int i = 0; i < 16; i++)
            if (5'(i) >= vb_sat)
                padded[127 - 8*i -: 8] = 8'(5'd16 - vb_sat);
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:   if (in_acc) st_next = in_msg_reg ? ST_LOAD : ST_EXPAND;
            ST_EXPAND: if (!ks_stat.busy) st_next = ST_LOAD;
            ST_LOAD:   st_next = ST_ROUND;
            ST_ROUND:  if (done && step_reg) st_next = ST_OUTPUT;
            ST_OUTPUT: if (out_acc) st_next = extra_reg ? ST_PADBLK : ST_IDLE;
            ST_PADBLK: st_next = ST_ROUND;
            default:   st_next = ST_IDLE;
        endcase
    end

    // datapath and output control
    always_comb
    begin
        in_msg_next = in_msg_reg;
        chain_next  = chain_reg;
        blk_next    = blk_reg;
        last_next   = last_reg;
        dec_op_next = dec_op_reg;
        ecb_next    = ecb_reg;
        extra_next  = extra_reg;
        rnd_next    = rnd_reg;
        step_next   = 1'b0;
        res_next    = res_reg;
        ovb_next    = ovb_reg;
        olast_next  = olast_reg;
        ks_ctrl.start = 1'b0;
        ks_ctrl.key   = {key0_reg, key1_reg, key2_reg, key3_reg};
        dp_load     = 1'b0;
        dp_load_val = blk_reg;
        res_val     = dp_state;
        plain       = dp_state ^ chain_reg;
        pad_byte    = plain[7:0];
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    dec_op_next = dec_reg;
                    ecb_next    = !chain_en_reg;
                    last_next   = in_ch.last_block;
                    extra_next  = chain_en_reg && !dec_reg && in_ch.last_block
                                  && vb_sat == 5'd16;
                    if (!in_msg_reg)
                    begin
                        ks_ctrl.start = 1'b1;
                        chain_next    = {ivh_reg, ivl_reg};
                    end
                    in_msg_next = !in_ch.last_block;
                    blk_next = (chain_en_reg && !dec_reg) ? padded
                             : {in_ch.data_high, in_ch.data_low};
                end
            end
            ST_LOAD:
            begin
                dp_load     = 1'b1;
                dp_load_val = (!ecb_reg && !dec_op_reg) ? (blk_reg ^ chain_reg) : blk_reg;
                rnd_next    = dec_op_reg ? RoundW'(NumRounds) : '0;
            end
            ST_PADBLK:
            begin
                dp_load     = 1'b1;
                dp_load_val = {16{8'h10}} ^ chain_reg;
                rnd_next    = '0;
                extra_next  = 1'b0;
            end
            ST_ROUND:
            begin
                step_next = 1'b1;
                if (step_reg && !done)
                    rnd_next = dec_op_reg ? rnd_reg - RoundW'(1) : rnd_reg + RoundW'(1);
                if (step_reg && done)
                begin
                    ovb_next   = 5'd16;
                    olast_next = ecb_reg ? last_reg : (last_reg && !extra_reg);
                    if (ecb_reg)
                        res_next = dp_state;
                    else if (dec_op_reg)
                    begin
                        res_next   = plain;
                        chain_next = blk_reg;
                        if (last_reg && pad_byte >= 8'd1 && pad_byte <= 8'd16)
                            ovb_next = 5'(5'd16 - pad_byte[4:0]);
                    end
                    else
                    begin
                        res_next   = res_val;
                        chain_next = res_val;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            in_msg_reg <= 1'b0;
            chain_reg  <= '0;
            step_reg   <= 1'b0;
            rnd_reg    <= '0;
            extra_reg  <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            in_msg_reg <= in_msg_next;
            chain_reg  <= chain_next;
            step_reg   <= step_next;
            rnd_reg    <= rnd_next;
            extra_reg  <= extra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg    <= blk_next;
        last_reg   <= last_next;
        dec_op_reg <= dec_op_next;
        ecb_reg    <= ecb_next;
        res_reg    <= res_next;
        ovb_reg    <= ovb_next;
        olast_reg  <= olast_next;
    end

    aes_cbc_keysched u_keysched (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ks_ctrl),
        .stat      (ks_stat),
        .rd_round  (rnd_next),
        .rnd_key   (rnd_key)
    );

    aes_cbc_datapath u_datapath (
        .clk        (clk),
        .load       (dp_load),
        .load_value (dp_load_val),
        .step       (step_reg),
        .decrypt    (dec_op_reg),
        .round      (rnd_reg),
        .rnd_key    (rnd_key),
        .state_out  (dp_state)
    );

    // result request
    assign out_ch.valid           = (st_reg == ST_OUTPUT);
    assign out_ch.out_data_high   = res_reg[127:64];
    assign out_ch.out_data_low    = res_reg[63:0];
    assign out_ch.out_valid_bytes = ovb_reg;
    assign out_ch.out_last        = olast_reg;
endmodule
